>>> hdl/rqdel_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rqdel_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W       = CNT_W + 1;

  localparam int unsigned TYPE_W = 2;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned MSG_W  = 64;
  localparam int unsigned CMD_W  = 8;
  localparam int unsigned OCNT_W = 5;

  typedef enum logic [TYPE_W-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_READ   = 2'd2,
    REQ_DELETE = 2'd3
  } req_kind_e;

  // Slot of the record at a position from the head, wrapped modulo the depth.
  function automatic logic [SLOT_W-1:0] slot_at(input logic [SLOT_W-1:0] head,
                                                input logic [CNT_W-1:0]  pos);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(pos);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/rqdel_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rqdel_req_if;
  logic                          valid;
  logic                          ready;
  logic [rqdel_pkg::TYPE_W-1:0]  req_type;
  logic [rqdel_pkg::POS_W-1:0]   entry_index;
  logic [rqdel_pkg::MSG_W-1:0]   message_in;
  logic [rqdel_pkg::CMD_W-1:0]   command_in;

  modport source (output valid, req_type, entry_index, message_in, command_in,
                  input ready);
  modport sink   (input valid, req_type, entry_index, message_in, command_in,
                  output ready);
endinterface

interface rqdel_res_if;
  logic                          valid;
  logic                          ready;
  logic                          done_res;
  logic [rqdel_pkg::MSG_W-1:0]   message_out;
  logic [rqdel_pkg::CMD_W-1:0]   command_out;
  logic [rqdel_pkg::OCNT_W-1:0]  entry_count;

  modport source (output valid, done_res, message_out, command_out, entry_count,
                  input ready);
  modport sink   (input valid, done_res, message_out, command_out, entry_count,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/ring_queue_with_indexed_delete_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Circular queue of 16 command records (64-bit message, 8-bit command type) held
// in a single-port-write, registered-read memory. One request is taken at a time;
// ready is high only while the sequencer is idle. Push and refused requests
// finish without a memory read; pop and read wait for the registered read data,
// and a delete at position p walks every record behind p, because each record
// moved toward the head costs one memory read and one memory write. A finished
// result sits in the output register until it is taken, and the next request
// can be accepted meanwhile.
module ring_queue_with_indexed_delete_unit (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  rqdel_req_if.sink     req_i,
  rqdel_res_if.source   res_o
);
  import rqdel_pkg::*;

  localparam int unsigned ENT_W = MSG_W + CMD_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RDATA = 3'd2;
  localparam logic [2:0] S_SHRD  = 3'd3;
  localparam logic [2:0] S_SHWR  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [SLOT_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  iter_q, iter_d;

  req_kind_e         kind_q;
  logic [CNT_W-1:0]  pos_q;
  logic [MSG_W-1:0]  msg_q;
  logic [CMD_W-1:0]  cmd_q;

  logic              done_q, done_d;
  logic [ENT_W-1:0]  rec_q, rec_d;

  logic              out_valid_q;
  logic              out_done_q;
  logic [MSG_W-1:0]  out_msg_q;
  logic [CMD_W-1:0]  out_cmd_q;
  logic [OCNT_W-1:0] out_cnt_q;

  logic [ENT_W-1:0]  mem [QUEUE_DEPTH];
  logic [ENT_W-1:0]  rdata_q;
  logic [SLOT_W-1:0] raddr;
  logic              we;
  logic [SLOT_W-1:0] waddr;
  logic [ENT_W-1:0]  wdata;

  logic              in_fire;
  logic              out_free;

  assign in_fire  = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || res_o.ready;

  assign req_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    count_d = count_q;
    iter_d  = iter_q;
    done_d  = done_q;
    rec_d   = rec_q;
    raddr   = head_q;
    we      = 1'b0;
    waddr   = slot_at(head_q, count_q);
    wdata   = {msg_q, cmd_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        done_d  = 1'b0;
        rec_d   = '0;
        state_d = S_FIN;
        unique case (kind_q)
          REQ_PUSH: begin
            if (count_q < CNT_W'(QUEUE_DEPTH)) begin
              we      = 1'b1;
              count_d = count_q + 1'b1;
              done_d  = 1'b1;
            end
          end
          REQ_POP: begin
            if (count_q != '0) begin
              raddr   = head_q;
              head_d  = slot_at(head_q, CNT_W'(1));
              count_d = count_q - 1'b1;
              done_d  = 1'b1;
              state_d = S_RDATA;
            end
          end
          REQ_READ: begin
            if (pos_q < count_q) begin
              raddr   = slot_at(head_q, pos_q);
              done_d  = 1'b1;
              state_d = S_RDATA;
            end
          end
          REQ_DELETE: begin
            if (pos_q < count_q) begin
              iter_d  = pos_q + 1'b1;
              state_d = S_SHRD;
            end
          end
          default: ;
        endcase
      end
      S_RDATA: begin
        rec_d   = rdata_q;
        state_d = S_FIN;
      end
      S_SHRD: begin
        if (iter_q < count_q) begin
          raddr   = slot_at(head_q, iter_q);
          state_d = S_SHWR;
        end else begin
          count_d = count_q - 1'b1;
          done_d  = 1'b1;
          state_d = S_FIN;
        end
      end
      S_SHWR: begin
        // Move the record just read one slot toward the head.
        we      = 1'b1;
        waddr   = slot_at(head_q, iter_q - 1'b1);
        wdata   = rdata_q;
        iter_d  = iter_q + 1'b1;
        state_d = S_SHRD;
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    done_q <= done_d;
    rec_q  <= rec_d;
    if (in_fire) begin
      kind_q <= req_kind_e'(req_i.req_type);
      pos_q  <= CNT_W'(req_i.entry_index);
      msg_q  <= req_i.message_in;
      cmd_q  <= req_i.command_in;
    end
    if (state_q == S_FIN && out_free) begin
      out_done_q <= done_q;
      out_msg_q  <= rec_q[ENT_W-1:CMD_W];
      out_cmd_q  <= rec_q[CMD_W-1:0];
      out_cnt_q  <= OCNT_W'(count_q);
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.done_res    = out_done_q;
  assign res_o.message_out = out_msg_q;
  assign res_o.command_out = out_cmd_q;
  assign res_o.entry_count = out_cnt_q;

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import rqdel_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    req_kind_e           kind;
    logic [POS_W-1:0]    index;
    logic [MSG_W-1:0]    message;
    logic [CMD_W-1:0]    command;
  } request_t;

  typedef struct packed {
    logic                done;
    logic [MSG_W-1:0]    message;
    logic [CMD_W-1:0]    command;
    logic [OCNT_W-1:0]   count;
  } outcome_t;

  // Mirror of the ring: records, head slot and count, plus the outcomes still owed.
  class queue_checker;
    logic [MSG_W-1:0] msg_slots [QUEUE_DEPTH];
    logic [CMD_W-1:0] cmd_slots [QUEUE_DEPTH];
    int unsigned      head_slot;
    int unsigned      held;
    outcome_t         pending_outcomes [$];
    int unsigned      errors;

    function new();
      head_slot = 0;
      held      = 0;
      errors    = 0;
    endfunction

    function int unsigned slot_of(int unsigned pos);
      return (head_slot + pos) % QUEUE_DEPTH;
    endfunction

    function outcome_t predict_outcome(request_t rq);
      outcome_t    o;
      int unsigned i;
      o = '0;
      case (rq.kind)
        REQ_PUSH: begin
          if (held < QUEUE_DEPTH) begin
            msg_slots[slot_of(held)] = rq.message;
            cmd_slots[slot_of(held)] = rq.command;
            held++;
            o.done = 1'b1;
          end
        end
        REQ_POP: begin
          if (held != 0) begin
            o.message = msg_slots[head_slot];
            o.command = cmd_slots[head_slot];
            head_slot = (head_slot + 1) % QUEUE_DEPTH;
            held--;
            o.done = 1'b1;
          end
        end
        REQ_READ: begin
          if (rq.index < held) begin
            o.message = msg_slots[slot_of(rq.index)];
            o.command = cmd_slots[slot_of(rq.index)];
            o.done    = 1'b1;
          end
        end
        default: begin
          if (rq.index < held) begin
            // Every later record moves one slot toward the head, across the wrap.
            for (i = rq.index + 1; i < held; i++) begin
              msg_slots[slot_of(i - 1)] = msg_slots[slot_of(i)];
              cmd_slots[slot_of(i - 1)] = cmd_slots[slot_of(i)];
            end
            held--;
            o.done = 1'b1;
          end
        end
      endcase
      o.count = OCNT_W'(held);
      return o;
    endfunction

    function void note_request(request_t rq);
      pending_outcomes.push_back(predict_outcome(rq));
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(outcome_t got);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        report($sformatf("result beat with nothing outstanding (done %b count %0d)",
                         got.done, got.count));
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.done !== want.done)
        report($sformatf("done_res got %b want %b", got.done, want.done));
      if (got.message !== want.message)
        report($sformatf("message_out got %h want %h", got.message, want.message));
      if (got.command !== want.command)
        report($sformatf("command_out got %h want %h", got.command, want.command));
      if (got.count !== want.count)
        report($sformatf("entry_count got %0d want %0d", got.count, want.count));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  int unsigned cycles;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned sink_hold;
  bit          draining;

  queue_checker sb = new();

  rqdel_req_if req_if ();
  rqdel_res_if res_if ();

  ring_queue_with_indexed_delete_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Beats are taken at the rising edge, before the block updates anything.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      sb.check_result('{done: res_if.done_res, message: res_if.message_out,
                        command: res_if.command_out, count: res_if.entry_count});
    end
    if (rst_ni && req_if.valid && req_if.ready) begin
      sb.note_request('{kind: req_kind_e'(req_if.req_type), index: req_if.entry_index,
                        message: req_if.message_in, command: req_if.command_in});
    end
  end

  // Result side: random back-pressure, or a long hold-off when one is requested.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        sink_hold    = sink_hold - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic send_req(req_kind_e kind, logic [POS_W-1:0] idx,
                          logic [MSG_W-1:0] msg, logic [CMD_W-1:0] cmd);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= kind;
    req_if.entry_index <= idx;
    req_if.message_in  <= msg;
    req_if.command_in  <= cmd;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_outcomes.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [MSG_W-1:0] pick_message();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 15) return '1;
    return {$urandom, $urandom};
  endfunction

  // Fill and drain in turns so that the count sweeps between empty and full.
  task automatic send_random();
    int unsigned      roll;
    req_kind_e        kind;
    logic [POS_W-1:0] idx;
    if (sb.held == QUEUE_DEPTH) draining = 1'b1;
    else if (sb.held == 0) draining = 1'b0;
    else if ($urandom_range(99) < 3) draining = ~draining;
    roll = $urandom_range(99);
    if (!draining) begin
      kind = roll < 50 ? REQ_PUSH : roll < 65 ? REQ_POP : roll < 85 ? REQ_READ : REQ_DELETE;
    end else begin
      kind = roll < 20 ? REQ_PUSH : roll < 50 ? REQ_POP : roll < 70 ? REQ_READ : REQ_DELETE;
    end
    if (sb.held > 0 && $urandom_range(99) < 85) idx = POS_W'($urandom_range(sb.held - 1));
    else idx = POS_W'($urandom_range(15));
    send_req(kind, idx, pick_message(), CMD_W'($urandom));
  endtask

  initial begin
    int unsigned i;
    rst_ni             = 1'b0;
    cycles             = 0;
    sink_hold          = 0;
    draining           = 1'b0;
    src_idle_pct       = 9;
    sink_idle_pct      = 70;
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_PUSH;
    req_if.entry_index = '0;
    req_if.message_in  = '0;
    req_if.command_in  = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Refusals on an empty queue, then fill to the brim, the first two records all zeros and all ones.
    send_req(REQ_POP, '0, '1, '1);
    send_req(REQ_DELETE, 4'hF, '1, '1);
    for (i = 0; i < QUEUE_DEPTH; i++) begin
      send_req(REQ_PUSH, POS_W'(i),
               i == 0 ? '0 : i == 1 ? '1 : {$urandom, $urandom},
               i == 0 ? '0 : i == 1 ? 8'hFF : CMD_W'($urandom));
    end
    send_req(REQ_PUSH, '0, {$urandom, $urandom}, CMD_W'($urandom));
    send_req(REQ_READ, 4'hF, '0, '0);
    send_req(REQ_POP, '0, '0, '0);
    send_req(REQ_POP, '0, '0, '0);
    // The tail now wraps past slot zero, so deleting the head shifts across the wrap.
    send_req(REQ_PUSH, '0, {$urandom, $urandom}, CMD_W'($urandom));
    send_req(REQ_PUSH, '0, {$urandom, $urandom}, CMD_W'($urandom));
    send_req(REQ_DELETE, '0, '0, '0);
    send_req(REQ_DELETE, 4'd14, '0, '0);
    send_req(REQ_READ, 4'd14, '0, '0);

    for (i = 0; i < 210; i++) send_random();
    wait_drained();

    src_idle_pct  = 70;
    sink_idle_pct = 9;
    for (i = 0; i < 210; i++) send_random();
    wait_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    for (i = 0; i < 210; i++) begin
      if (i == 40) sink_hold = HOLD_CYCLES;
      send_random();
    end
    wait_drained();
    repeat (60) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/rqdel_pkg.sv
hdl/rqdel_if.sv
hdl/ring_queue_with_indexed_delete_unit.sv
dv/tb.sv
